FILE: hw/rtl/tnoc_pkg.sv
package tnoc_pkg;

    // fixed widths of the item fields and the threshold registers
    localparam int FIELD_WIDTH     = 32;
    localparam int REG_WIDTH       = 64;
    localparam int CFG_INDEX_WIDTH = 1;

    // |w|^2 is Q68.64, the cross threshold is Q32.32
    localparam int SQ_SHIFT = 32;

    // register stages from input to result
    localparam int PIPE_DEPTH = 7;

    typedef enum logic [1:0] {
        CLASS_INVALID = 2'd0,
        CLASS_TOWARD  = 2'd1,
        CLASS_AWAY    = 2'd2
    } class_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_NORMAL_MIN_SQ = 1'b0,
        REG_CROSS_MIN_SQ  = 1'b1
    } cfg_reg_t;

    // per-item status carried down the pipeline after the normal test
    typedef struct packed {
        logic   nvalid;
        class_t cls;
    } flags_t;

endpackage

FILE: hw/rtl/tnoc_if.sv
interface tnoc_tri_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   normal_x;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   normal_y;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   normal_z;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   a_x;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   a_y;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   a_z;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   b_x;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   b_y;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   b_z;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   c_x;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   c_y;
    logic signed [tnoc_pkg::FIELD_WIDTH-1:0]   c_z;

    modport source (
        output valid, normal_x, normal_y, normal_z, a_x, a_y, a_z,
               b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );

    modport sink (
        input  valid, normal_x, normal_y, normal_z, a_x, a_y, a_z,
               b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

interface tnoc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] normal_class;
    logic       reverse_face;

    modport source (
        output valid, normal_class, reverse_face,
        input  ready
    );

    modport sink (
        input  valid, normal_class, reverse_face,
        output ready
    );
endinterface

FILE: hw/rtl/tnoc_prep.sv
module tnoc_prep #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tnoc_tri_if.sink                          face,
    input  logic                              down_ready,
    output logic                              prod_valid,
    output logic signed [2*COORD_WIDTH-1:0]   nn [3],
    output logic signed [2*COORD_WIDTH+1:0]   ns [3],
    output logic signed [2*COORD_WIDTH+1:0]   xp [6],
    output logic signed [COORD_WIDTH-1:0]     n [3]
);

    localparam int W    = COORD_WIDTH;
    localparam int S_W  = W + 2;
    localparam int E_W  = W + 1;
    localparam int NN_W = 2 * W;
    localparam int NS_W = 2 * W + 2;
    localparam int XP_W = 2 * W + 2;

    logic signed [W-1:0]    nc [3];
    logic signed [W-1:0]    ac [3];
    logic signed [W-1:0]    bc [3];
    logic signed [W-1:0]    cc [3];

    logic                   s1_valid_reg;
    logic                   s1_ready;
    logic signed [W-1:0]    n1_reg [3];
    logic signed [S_W-1:0]  vsum_next [3];
    logic signed [S_W-1:0]  vsum_reg [3];
    logic signed [E_W-1:0]  e1_next [3];
    logic signed [E_W-1:0]  e1_reg [3];
    logic signed [E_W-1:0]  e2_next [3];
    logic signed [E_W-1:0]  e2_reg [3];

    logic                   s2_valid_reg;
    logic                   s2_ready;
    logic signed [W-1:0]    n2_reg [3];
    logic signed [NN_W-1:0] nn_next [3];
    logic signed [NN_W-1:0] nn_reg [3];
    logic signed [NS_W-1:0] ns_next [3];
    logic signed [NS_W-1:0] ns_reg [3];
    logic signed [XP_W-1:0] xp_next [6];
    logic signed [XP_W-1:0] xp_reg [6];

    // coordinates taken from the low bits of each field
    assign nc[0] = $signed(face.normal_x[W-1:0]);
    assign nc[1] = $signed(face.normal_y[W-1:0]);
    assign nc[2] = $signed(face.normal_z[W-1:0]);
    assign ac[0] = $signed(face.a_x[W-1:0]);
    assign ac[1] = $signed(face.a_y[W-1:0]);
    assign ac[2] = $signed(face.a_z[W-1:0]);
    assign bc[0] = $signed(face.b_x[W-1:0]);
    assign bc[1] = $signed(face.b_y[W-1:0]);
    assign bc[2] = $signed(face.b_z[W-1:0]);
    assign cc[0] = $signed(face.c_x[W-1:0]);
    assign cc[1] = $signed(face.c_y[W-1:0]);
    assign cc[2] = $signed(face.c_z[W-1:0]);

    // stage handshake: a stage loads when empty or when its successor moves
    assign s2_ready   = !s2_valid_reg || down_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign face.ready = s1_ready;

    // stage 1: vertex sum and edge vectors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vsum_next[i] = S_W'(ac[i]) + S_W'(bc[i]) + S_W'(cc[i]);
            e1_next[i]   = E_W'(bc[i]) - E_W'(ac[i]);
            e2_next[i]   = E_W'(cc[i]) - E_W'(ac[i]);
        end
    end

    // stage 2: normal squares, normal times vertex sum, cross partial products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nn_next[i] = NN_W'(n1_reg[i]) * NN_W'(n1_reg[i]);
            ns_next[i] = NS_W'(n1_reg[i]) * NS_W'(vsum_reg[i]);
        end
        xp_next[0] = XP_W'(e1_reg[1]) * XP_W'(e2_reg[2]);
        xp_next[1] = XP_W'(e1_reg[2]) * XP_W'(e2_reg[1]);
        xp_next[2] = XP_W'(e1_reg[2]) * XP_W'(e2_reg[0]);
        xp_next[3] = XP_W'(e1_reg[0]) * XP_W'(e2_reg[2]);
        xp_next[4] = XP_W'(e1_reg[0]) * XP_W'(e2_reg[1]);
        xp_next[5] = XP_W'(e1_reg[1]) * XP_W'(e2_reg[0]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= face.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && face.valid)
        begin
            n1_reg   <= nc;
            vsum_reg <= vsum_next;
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            n2_reg <= n1_reg;
            nn_reg <= nn_next;
            ns_reg <= ns_next;
            xp_reg <= xp_next;
        end
    end

    assign prod_valid = s2_valid_reg;
    assign nn         = nn_reg;
    assign ns         = ns_reg;
    assign xp         = xp_reg;
    assign n          = n2_reg;

endmodule

FILE: hw/rtl/tnoc_reduce.sv
module tnoc_reduce #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   up_valid,
    output logic                                   up_ready,
    input  logic signed [2*COORD_WIDTH-1:0]        nn [3],
    input  logic signed [2*COORD_WIDTH+1:0]        ns [3],
    input  logic signed [2*COORD_WIDTH+1:0]        xp [6],
    input  logic signed [COORD_WIDTH-1:0]          n_in [3],
    input  logic [tnoc_pkg::REG_WIDTH-1:0]         normal_min_sq,
    input  logic                                   down_ready,
    output logic                                   red_valid,
    output tnoc_pkg::flags_t                       flags,
    output logic signed [2*COORD_WIDTH+2:0]        w [3],
    output logic signed [COORD_WIDTH-1:0]          n_out [3]
);

    localparam int W     = COORD_WIDTH;
    localparam int NSQ_W = 2 * W;
    localparam int DS_W  = 2 * W + 4;
    localparam int W_W   = 2 * W + 3;

    logic                    s3_valid_reg;
    logic                    s3_ready;
    logic [NSQ_W-1:0]        nsq;
    logic signed [DS_W-1:0]  ds;
    logic                    nvalid;
    tnoc_pkg::flags_t        flags_next;
    tnoc_pkg::flags_t        flags_reg;
    logic signed [W_W-1:0]   w_next [3];
    logic signed [W_W-1:0]   w_reg [3];
    logic signed [W-1:0]     n_reg [3];

    assign s3_ready = !s3_valid_reg || down_ready;
    assign up_ready = s3_ready;

    // squared normal length against the threshold
    assign nsq    = $unsigned(nn[0]) + $unsigned(nn[1]) + $unsigned(nn[2]);
    assign nvalid = tnoc_pkg::REG_WIDTH'(nsq) > normal_min_sq;

    // dot of the normal with the vertex sum: negative means toward origin
    assign ds = DS_W'(ns[0]) + DS_W'(ns[1]) + DS_W'(ns[2]);

    always_comb
    begin
        flags_next.nvalid = nvalid;
        if (!nvalid)
        begin
            flags_next.cls = tnoc_pkg::CLASS_INVALID;
        end
        else if (ds[DS_W-1])
        begin
            flags_next.cls = tnoc_pkg::CLASS_TOWARD;
        end
        else
        begin
            flags_next.cls = tnoc_pkg::CLASS_AWAY;
        end
    end

    // winding normal components
    assign w_next[0] = W_W'(xp[0]) - W_W'(xp[1]);
    assign w_next[1] = W_W'(xp[2]) - W_W'(xp[3]);
    assign w_next[2] = W_W'(xp[4]) - W_W'(xp[5]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && up_valid)
        begin
            flags_reg <= flags_next;
            w_reg     <= w_next;
            n_reg     <= n_in;
        end
    end

    assign red_valid = s3_valid_reg;
    assign flags     = flags_reg;
    assign w         = w_reg;
    assign n_out     = n_reg;

endmodule

FILE: hw/rtl/tnoc_wide.sv
module tnoc_wide #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  tnoc_pkg::flags_t                   flags_in,
    input  logic signed [2*COORD_WIDTH+2:0]    w [3],
    input  logic signed [COORD_WIDTH-1:0]      n [3],
    input  logic                               down_ready,
    output logic                               wide_valid,
    output tnoc_pkg::flags_t                   flags_out,
    output logic [4*COORD_WIDTH+3:0]           w2,
    output logic signed [3*COORD_WIDTH+2:0]    wn
);

    localparam int W    = COORD_WIDTH;
    localparam int W_W  = 2 * W + 3;
    localparam int K    = W + 2;
    localparam int HI_W = W_W - K;
    localparam int HH_W = 2 * HI_W;
    localparam int HL_W = HI_W + K + 1;
    localparam int LL_W = 2 * K;
    localparam int HN_W = HI_W + W;
    localparam int LN_W = K + 1 + W;
    localparam int SQ_W = 4 * W + 4;
    localparam int WN_W = 3 * W + 3;

    logic                    s4_valid_reg;
    logic                    s5_valid_reg;
    logic                    s6_valid_reg;
    logic                    s4_ready;
    logic                    s5_ready;
    logic                    s6_ready;
    tnoc_pkg::flags_t        flags4_reg;
    tnoc_pkg::flags_t        flags5_reg;
    tnoc_pkg::flags_t        flags6_reg;

    logic signed [HI_W-1:0]  hi [3];
    logic signed [K:0]       lo [3];
    logic signed [HH_W-1:0]  hh_next [3];
    logic signed [HH_W-1:0]  hh_reg [3];
    logic signed [HL_W-1:0]  hl_next [3];
    logic signed [HL_W-1:0]  hl_reg [3];
    logic [LL_W-1:0]         ll_next [3];
    logic [LL_W-1:0]         ll_reg [3];
    logic signed [HN_W-1:0]  hn_next [3];
    logic signed [HN_W-1:0]  hn_reg [3];
    logic signed [LN_W-1:0]  ln_next [3];
    logic signed [LN_W-1:0]  ln_reg [3];

    logic [SQ_W-1:0]         sq_next [3];
    logic [SQ_W-1:0]         sq_reg [3];
    logic signed [WN_W-1:0]  wnc_next [3];
    logic signed [WN_W-1:0]  wnc_reg [3];

    logic [SQ_W-1:0]         w2_next;
    logic [SQ_W-1:0]         w2_reg;
    logic signed [WN_W-1:0]  wn_next;
    logic signed [WN_W-1:0]  wn_reg;

    assign s6_ready = !s6_valid_reg || down_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign up_ready = s4_ready;

    // stage 4: split each w into signed high, unsigned low; partial products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hi[i]      = w[i][W_W-1:K];
            lo[i]      = $signed({1'b0, w[i][K-1:0]});
            hh_next[i] = HH_W'(hi[i]) * HH_W'(hi[i]);
            hl_next[i] = HL_W'(hi[i]) * HL_W'(lo[i]);
            ll_next[i] = LL_W'(w[i][K-1:0]) * LL_W'(w[i][K-1:0]);
            hn_next[i] = HN_W'(hi[i]) * HN_W'(n[i]);
            ln_next[i] = LN_W'(lo[i]) * LN_W'(n[i]);
        end
    end

    // stage 5: recombine partial products per component, exact modulo width
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i]  = (SQ_W'(hh_reg[i]) << (2 * K))
                        + (SQ_W'(hl_reg[i]) << (K + 1))
                        + SQ_W'(ll_reg[i]);
            wnc_next[i] = (WN_W'(hn_reg[i]) << K) + WN_W'(ln_reg[i]);
        end
    end

    // stage 6: sums over the three components
    assign w2_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign wn_next = wnc_reg[0] + wnc_reg[1] + wnc_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= up_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (s6_ready)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && up_valid)
        begin
            flags4_reg <= flags_in;
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            ll_reg     <= ll_next;
            hn_reg     <= hn_next;
            ln_reg     <= ln_next;
        end
        if (s5_ready && s4_valid_reg)
        begin
            flags5_reg <= flags4_reg;
            sq_reg     <= sq_next;
            wnc_reg    <= wnc_next;
        end
        if (s6_ready && s5_valid_reg)
        begin
            flags6_reg <= flags5_reg;
            w2_reg     <= w2_next;
            wn_reg     <= wn_next;
        end
    end

    assign wide_valid = s6_valid_reg;
    assign flags_out  = flags6_reg;
    assign w2         = w2_reg;
    assign wn         = wn_reg;

endmodule

FILE: hw/rtl/triangle_normal_orientation_check.sv
// channel    | dir | handshake     | payload
// triangle   | in  | valid / ready | normal_x..z, a_x..z, b_x..z, c_x..z (32b signed each)
// result     | out | valid / ready | normal_class (2b), reverse_face (1b)
// cfg        | in  | cfg_wr_en     | cfg_index (1b), cfg_wr_data (64b)
//
// one item per cycle sustained while result.ready holds; each item passes
// through the seven register stages (prep, products, reduce, split multiply,
// recombine, sum, output compare)
// reset clears every stage valid bit and both thresholds to zero
// a stalled result holds in the output register; each stage keeps filling while
// the stage after it is empty, so bubbles close up and nothing is dropped
module triangle_normal_orientation_check #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    tnoc_tri_if.sink                               triangle,
    tnoc_res_if.source                             result,
    input  logic                                   cfg_wr_en,
    input  logic [tnoc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tnoc_pkg::REG_WIDTH-1:0]         cfg_wr_data
);

    localparam int W     = COORD_WIDTH;
    localparam int W_W   = 2 * W + 3;
    localparam int SQ_W  = 4 * W + 4;
    localparam int WN_W  = 3 * W + 3;
    localparam int THR_W = tnoc_pkg::REG_WIDTH + tnoc_pkg::SQ_SHIFT;
    localparam int CMP_W = (SQ_W > THR_W) ? SQ_W : THR_W;

    logic [tnoc_pkg::REG_WIDTH-1:0]  normal_min_sq_reg;
    logic [tnoc_pkg::REG_WIDTH-1:0]  cross_min_sq_reg;

    logic                            prod_valid;
    logic                            red_ready;
    logic signed [2*W-1:0]           nn [3];
    logic signed [2*W+1:0]           ns [3];
    logic signed [2*W+1:0]           xp [6];
    logic signed [W-1:0]             n_prod [3];

    logic                            red_valid;
    logic                            wide_ready;
    tnoc_pkg::flags_t                red_flags;
    logic signed [W_W-1:0]           w_vec [3];
    logic signed [W-1:0]             n_red [3];

    logic                            wide_valid;
    logic                            out_ready;
    tnoc_pkg::flags_t                wide_flags;
    logic [SQ_W-1:0]                 w2;
    logic signed [WN_W-1:0]          wn;

    logic [THR_W-1:0]                cross_thr;
    logic                            cross_ok;
    logic                            rev_next;
    logic                            res_valid_reg;
    tnoc_pkg::class_t                class_reg;
    logic                            rev_reg;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_min_sq_reg <= '0;
            cross_min_sq_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (tnoc_pkg::cfg_reg_t'(cfg_index))
                tnoc_pkg::REG_NORMAL_MIN_SQ: normal_min_sq_reg <= cfg_wr_data;
                tnoc_pkg::REG_CROSS_MIN_SQ:  cross_min_sq_reg  <= cfg_wr_data;
                default:                     ;
            endcase
        end
    end

    tnoc_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .face       (triangle),
        .down_ready (red_ready),
        .prod_valid (prod_valid),
        .nn         (nn),
        .ns         (ns),
        .xp         (xp),
        .n          (n_prod)
    );

    tnoc_reduce #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (prod_valid),
        .up_ready      (red_ready),
        .nn            (nn),
        .ns            (ns),
        .xp            (xp),
        .n_in          (n_prod),
        .normal_min_sq (normal_min_sq_reg),
        .down_ready    (wide_ready),
        .red_valid     (red_valid),
        .flags         (red_flags),
        .w             (w_vec),
        .n_out         (n_red)
    );

    tnoc_wide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_wide (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (red_valid),
        .up_ready   (wide_ready),
        .flags_in   (red_flags),
        .w          (w_vec),
        .n          (n_red),
        .down_ready (out_ready),
        .wide_valid (wide_valid),
        .flags_out  (wide_flags),
        .w2         (w2),
        .wn         (wn)
    );

    // |w|^2 rounded up to Q32.32 exceeds the threshold iff the exact value exceeds
    // the threshold scaled up; an all-ones threshold can never be exceeded
    assign cross_thr = {cross_min_sq_reg, {tnoc_pkg::SQ_SHIFT{1'b0}}};
    assign cross_ok  = !(&cross_min_sq_reg) && (CMP_W'(w2) > CMP_W'(cross_thr));
    assign rev_next  = wide_flags.nvalid && cross_ok && wn[WN_W-1];

    // output register
    assign out_ready = !res_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            res_valid_reg <= wide_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && wide_valid)
        begin
            class_reg <= wide_flags.cls;
            rev_reg   <= rev_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.normal_class = class_reg;
    assign result.reverse_face = rev_reg;

endmodule

FILE: hw/rtl/tnoc_checker.sv
module tnoc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] normal_class,
    input logic       reverse_face
);

    localparam int OCC_W = $clog2(tnoc_pkg::PIPE_DEPTH + 2);

    logic             in_fire;
    logic             out_fire;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // items taken in and not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (in_fire && !out_fire)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (out_fire && !in_fire)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // a result waiting on the sink stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

    // a waiting result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(normal_class) && $stable(reverse_face))
    else $error("result changed while stalled");

    // reverse only on a valid normal, and no unused class code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_class == tnoc_pkg::CLASS_TOWARD)
                   || (normal_class == tnoc_pkg::CLASS_AWAY)
                   || ((normal_class == tnoc_pkg::CLASS_INVALID) && !reverse_face))
    else $error("bad class or reverse flag on invalid normal");

    // no result without an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
    else $error("result with no item in flight");

    // the pipeline never holds more items than it has stages
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(tnoc_pkg::PIPE_DEPTH))
    else $error("more items in flight than stages");

endmodule

bind triangle_normal_orientation_check tnoc_checker u_tnoc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (triangle.valid),
    .in_ready     (triangle.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .normal_class (result.normal_class),
    .reverse_face (result.reverse_face)
);
